>>> rtl/core/stt_pkg.sv
// Shared types, codes and character classes for the source text tokenizer.
package stt_pkg;

	// Error codes carried on each result
	localparam logic [1:0] ERR_NONE         = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG     = 2'd1;
	localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

	// Most results that one input item can cause
	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;

	// One result item
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       token_done;
		logic [1:0] error_code;
		logic       last;
	} res_t;

	// Space, tab, LF, VT, FF and CR
	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Single-character tokens ( ) { } = + - * / ; ,
	function automatic logic is_separator(input logic [7:0] c);
		logic hit;
		case (c)
			8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3D, 8'h2B,
			8'h2D, 8'h2A, 8'h2F, 8'h3B, 8'h2C: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

>>> rtl/core/source_text_tokenizer_unit.sv
// Source text tokenizer: one byte in per item, token bytes and end marks out.
// An item is held in the input register, then its results load the result register.
// Throughput: one item per cycle while each item causes at most one result
// and m_tready is high; an item's results hold the result register until taken.
// Items that cause no result (blanks between tokens) never touch the result register.
// Reset clears token length, string flag, error latch and all valid state.
module source_text_tokenizer_unit #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] has_byte, [9] token_done,
	                               // [11:10] error_code, [15:12] zero
	output logic        m_tlast    // last result of the item
);

	localparam int unsigned LEN_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 1);

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;

	// Tokenizer state
	logic [LEN_W-1:0] len_q;
	logic             inq_q;
	logic [1:0]       err_q;

	// Result group register
	stt_pkg::res_t res_q [stt_pkg::MAX_RESULTS];
	logic [1:0]    cnt_q;

	// Next values from the item in the input register
	stt_pkg::res_t    res_n [stt_pkg::MAX_RESULTS];
	logic [1:0]       k;
	logic [LEN_W-1:0] len_n;
	logic             inq_n;
	logic [1:0]       err_n;

	logic grp_free, s1_go, out_fire;

	// Work out the results and next state for one byte
	always_comb begin
		for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
			res_n[i] = '0;
		end
		k     = 2'd0;
		len_n = len_q;
		inq_n = inq_q;
		err_n = err_q;

		if (err_q != stt_pkg::ERR_NONE) begin
			res_n[k].error_code = err_q;
			k = k + 2'd1;
		end else if (inq_q) begin
			if (byte_s1 == stt_pkg::CHAR_QUOTE) begin
				res_n[k] = '{data: byte_s1, has_byte: 1'b1, token_done: 1'b1,
					error_code: stt_pkg::ERR_NONE, last: 1'b0};
				k = k + 2'd1;
				inq_n = 1'b0;
				len_n = '0;
			end else if (len_q >= LEN_LIMIT) begin
				res_n[k].error_code = stt_pkg::ERR_TOO_LONG;
				k = k + 2'd1;
				err_n = stt_pkg::ERR_TOO_LONG;
			end else begin
				res_n[k] = '{data: byte_s1, has_byte: 1'b1, token_done: 1'b0,
					error_code: stt_pkg::ERR_NONE, last: 1'b0};
				k = k + 2'd1;
				len_n = len_q + LEN_W'(1);
				if (eos_s1) begin
					res_n[k].error_code = stt_pkg::ERR_UNTERMINATED;
					k = k + 2'd1;
					err_n = stt_pkg::ERR_UNTERMINATED;
				end
			end
		end else if (stt_pkg::is_blank(byte_s1)) begin
			if (len_q != '0) begin
				res_n[k].token_done = 1'b1;
				k = k + 2'd1;
			end
			len_n = '0;
		end else if (stt_pkg::is_separator(byte_s1)) begin
			if (len_q != '0) begin
				res_n[k].token_done = 1'b1;
				k = k + 2'd1;
			end
			res_n[k] = '{data: byte_s1, has_byte: 1'b1, token_done: 1'b1,
				error_code: stt_pkg::ERR_NONE, last: 1'b0};
			k = k + 2'd1;
			len_n = '0;
		end else if (byte_s1 == stt_pkg::CHAR_QUOTE) begin
			if (len_q != '0) begin
				res_n[k].token_done = 1'b1;
				k = k + 2'd1;
			end
			res_n[k] = '{data: byte_s1, has_byte: 1'b1, token_done: 1'b0,
				error_code: stt_pkg::ERR_NONE, last: 1'b0};
			k = k + 2'd1;
			len_n = LEN_W'(1);
			inq_n = 1'b1;
			if (eos_s1) begin
				res_n[k].error_code = stt_pkg::ERR_UNTERMINATED;
				k = k + 2'd1;
				err_n = stt_pkg::ERR_UNTERMINATED;
			end
		end else if (len_q >= LEN_LIMIT) begin
			res_n[k].error_code = stt_pkg::ERR_TOO_LONG;
			k = k + 2'd1;
			err_n = stt_pkg::ERR_TOO_LONG;
		end else begin
			res_n[k] = '{data: byte_s1, has_byte: 1'b1, token_done: eos_s1,
				error_code: stt_pkg::ERR_NONE, last: 1'b0};
			k = k + 2'd1;
			len_n = len_q + LEN_W'(1);
		end

		// End of source clears the token unless an error latched
		if (eos_s1 && (err_n == stt_pkg::ERR_NONE)) begin
			len_n = '0;
			inq_n = 1'b0;
		end

		// Mark the final result of the item
		for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
			res_n[i].last = (2'(i) + 2'd1 == k);
		end
	end

	// Handshake
	assign out_fire = m_tvalid && m_tready;
	assign grp_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign s1_go    = valid_s1 && ((k == 2'd0) || grp_free);
	assign s_tready = !valid_s1 || s1_go;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
			len_q    <= '0;
			inq_q    <= 1'b0;
			err_q    <= stt_pkg::ERR_NONE;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				len_q <= len_n;
				inq_q <= inq_n;
				err_q <= err_n;
			end
			if (s1_go && (k != 2'd0)) begin
				cnt_q <= k;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Payload: capture the item, load or advance the result group
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
		if (s1_go && (k != 2'd0)) begin
			for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
				res_q[i] <= res_n[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < stt_pkg::MAX_RESULTS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	// Drive the result port from the head of the group
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {4'b0000, res_q[0].error_code, res_q[0].token_done,
		res_q[0].has_byte, res_q[0].data};
	assign m_tlast  = res_q[0].last;

`ifndef SYNTHESIS
	// A latched error never changes until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != stt_pkg::ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("error latch changed after it was set");

	// The last result left in a group carries the last mark
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> m_tlast)
		else $error("final result of an item lacks the last mark");

	// An error result never carries a token byte
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[11:10] != stt_pkg::ERR_NONE)) |-> !m_tdata[8])
		else $error("error result carries a token byte");

	// Token length stays within the limit
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_LIMIT)
		else $error("token length beyond limit");

	// Once halted, only single results with the latched code come out
	a_halt_code: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (err_q != stt_pkg::ERR_NONE)) |=>
		(cnt_q == 2'd1) && (m_tdata[11:10] == $past(err_q)))
		else $error("halted item did not give one error result");
`endif

endmodule

>>> verif/source_text_tokenizer_unit_tb.sv
// Self-checking testbench for the source text tokenizer: predicts every result and checks it.
module source_text_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TOK_MAX      = 64;
	localparam int unsigned HALF_PERIOD  = 2;
	localparam int unsigned IDLE_PCT     = 18;
	localparam int unsigned RANDOM_ITEMS = 70;
	localparam int unsigned STEADY_ITEMS = 40;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// Separator and blank character sets, first character in the top byte
	localparam logic [8*11-1:0] SEPARATORS = "(){}=+-*/;,";
	localparam logic [8*6-1:0]  BLANKS     = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	localparam logic [7:0]      CH_SPACE   = 8'h20;
	localparam logic [7:0]      CH_SEMI    = ";";

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
	logic        s_tlast  = 1'b0;    // end_of_source
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;            // [7:0] out_byte, [8] has_byte, [9] token_done,
	                                 // [11:10] error_code, [15:12] zero
	logic        m_tlast;            // last result of the item

	// Predicted tokenizer state
	int unsigned tok_len  = 0;
	logic        in_str   = 1'b0;
	logic        halted   = 1'b0;
	logic [1:0]  err_kind = stt_pkg::ERR_NONE;

	stt_pkg::res_t lexeme_q[$];
	bit          steady = 1'b0;
	int unsigned fail_count = 0;
	int unsigned byte_count = 0;
	int unsigned source_ends = 0;
	int unsigned lexemes_checked = 0;
	int unsigned tokens_closed = 0;
	int unsigned cycle_count = 0;
	string       fault_path = "none";

	source_text_tokenizer_unit #(
		.MAX_LEN(TOK_MAX)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [7:0] sep_at(input int unsigned i);
		return SEPARATORS[8*(10-i) +: 8];
	endfunction

	function automatic logic [7:0] blank_at(input int unsigned i);
		return BLANKS[8*(5-i) +: 8];
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 6; i++)
			if (blank_at(i) == c)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic split_char(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 11; i++)
			if (sep_at(i) == c)
				hit = 1'b1;
		return hit;
	endfunction

	// Ordinary token byte: anything but blank, separator or quote
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (blank_char(c) || split_char(c) || c == stt_pkg::CHAR_QUOTE);
		return c;
	endfunction

	// Any byte that does not close a string
	function automatic logic [7:0] pick_text();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == stt_pkg::CHAR_QUOTE);
		return c;
	endfunction

	function automatic stt_pkg::res_t mark(input logic [7:0] b, input logic has,
			input logic done, input logic [1:0] code);
		stt_pkg::res_t r;
		r.data       = b;
		r.has_byte   = has;
		r.token_done = done;
		r.error_code = code;
		r.last       = 1'b0;
		return r;
	endfunction

	// Latch an error in the predicted state and give its result
	function automatic stt_pkg::res_t raise_fault(input logic [1:0] code);
		halted   = 1'b1;
		err_kind = code;
		return mark(8'h00, 1'b0, 1'b0, code);
	endfunction

	// Advance the predicted tokenizer by one byte and queue its results
	function automatic void tokenize_byte(input logic [7:0] c, input logic eos);
		stt_pkg::res_t batch[$];
		if (halted) begin
			batch.push_back(mark(8'h00, 1'b0, 1'b0, err_kind));
		end else if (in_str) begin
			if (c == stt_pkg::CHAR_QUOTE) begin
				batch.push_back(mark(c, 1'b1, 1'b1, stt_pkg::ERR_NONE));
				in_str  = 1'b0;
				tok_len = 0;
			end else if (tok_len >= TOK_MAX - 1) begin
				batch.push_back(raise_fault(stt_pkg::ERR_TOO_LONG));
			end else begin
				batch.push_back(mark(c, 1'b1, 1'b0, stt_pkg::ERR_NONE));
				tok_len++;
				if (eos)
					batch.push_back(raise_fault(stt_pkg::ERR_UNTERMINATED));
			end
		end else if (blank_char(c)) begin
			if (tok_len > 0)
				batch.push_back(mark(8'h00, 1'b0, 1'b1, stt_pkg::ERR_NONE));
			tok_len = 0;
		end else if (split_char(c)) begin
			if (tok_len > 0)
				batch.push_back(mark(8'h00, 1'b0, 1'b1, stt_pkg::ERR_NONE));
			batch.push_back(mark(c, 1'b1, 1'b1, stt_pkg::ERR_NONE));
			tok_len = 0;
		end else if (c == stt_pkg::CHAR_QUOTE) begin
			if (tok_len > 0)
				batch.push_back(mark(8'h00, 1'b0, 1'b1, stt_pkg::ERR_NONE));
			batch.push_back(mark(c, 1'b1, 1'b0, stt_pkg::ERR_NONE));
			tok_len = 1;
			in_str  = 1'b1;
			if (eos)
				batch.push_back(raise_fault(stt_pkg::ERR_UNTERMINATED));
		end else if (tok_len >= TOK_MAX - 1) begin
			batch.push_back(raise_fault(stt_pkg::ERR_TOO_LONG));
		end else begin
			batch.push_back(mark(c, 1'b1, eos, stt_pkg::ERR_NONE));
			tok_len++;
		end

		// A source end clears the token unless an error holds
		if (eos && !halted) begin
			tok_len = 0;
			in_str  = 1'b0;
		end

		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			lexeme_q.push_back(batch[i]);
	endfunction

	// Bend a byte so that it cannot latch an error
	function automatic void steer_clear(inout logic [7:0] c, inout logic eos);
		if (in_str) begin
			if (c != stt_pkg::CHAR_QUOTE && (tok_len >= TOK_MAX - 1 || eos))
				c = stt_pkg::CHAR_QUOTE;
		end else if (c == stt_pkg::CHAR_QUOTE) begin
			if (eos)
				c = CH_SEMI;
		end else if (!blank_char(c) && !split_char(c) && tok_len >= TOK_MAX - 1) begin
			c = CH_SPACE;
		end
	endfunction

	// Drive one item, hold it until accepted, then predict its results
	task automatic send_item(input logic [7:0] c, input logic eos);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		byte_count++;
		if (eos)
			source_ends++;
		tokenize_byte(c, eos);
	endtask

	task automatic send_clean(input logic [7:0] c, input logic eos);
		steer_clear(c, eos);
		send_item(c, eos);
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (lexeme_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Field extremes, every separator, every blank, quotes and source ends
	task automatic test_char_classes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h09, 1'b0);
		send_item("x", 1'b0);
		for (int i = 0; i < 11; i++)
			send_item(sep_at(i), 1'b0);
		for (int i = 0; i < 6; i++)
			send_item(blank_at(i), 1'b0);
		send_item("k", 1'b0);
		send_item(stt_pkg::CHAR_QUOTE, 1'b0);
		send_item(CH_SPACE, 1'b0);
		send_item(stt_pkg::CHAR_QUOTE, 1'b0);
		send_item("z", 1'b0);
		send_item("q", 1'b1);
		send_item(")", 1'b1);
	endtask

	// Longest identifier and longest string that pass without error
	task automatic test_length_limits();
		send_item(CH_SPACE, 1'b0);
		for (int i = 0; i < TOK_MAX - 1; i++)
			send_item(pick_plain(), 1'b0);
		send_item(CH_SPACE, 1'b0);
		for (int i = 0; i < TOK_MAX - 1; i++)
			send_item(pick_plain(), i == TOK_MAX - 2);
		send_item(stt_pkg::CHAR_QUOTE, 1'b0);
		for (int i = 0; i < TOK_MAX - 2; i++)
			send_item(pick_text(), 1'b0);
		send_item(stt_pkg::CHAR_QUOTE, 1'b1);
	endtask

	// Random source text made of tokens, with some raw noise mixed in;
	// the opening stretch runs with no idling on either side
	task automatic test_random_text();
		int unsigned goal, kind, len, first_byte;
		logic        end_here;
		first_byte = byte_count;
		goal = first_byte + RANDOM_ITEMS;
		while (byte_count < goal) begin
			steady   = (byte_count < first_byte + STEADY_ITEMS);
			kind     = $urandom_range(99);
			end_here = ($urandom_range(5) == 0);
			if (kind < 35) begin
				len = ($urandom_range(15) == 0) ? $urandom_range(40, TOK_MAX - 1)
				                                : $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					send_clean(pick_plain(), end_here && (k == len - 1));
			end else if (kind < 52) begin
				send_clean(sep_at($urandom_range(10)), end_here);
			end else if (kind < 67) begin
				len = $urandom_range(1, 3);
				for (int k = 0; k < len; k++)
					send_clean(blank_at($urandom_range(5)), end_here && (k == len - 1));
			end else if (kind < 85) begin
				len = ($urandom_range(11) == 0) ? $urandom_range(50, TOK_MAX - 2)
				                                : $urandom_range(0, 10);
				send_clean(stt_pkg::CHAR_QUOTE, 1'b0);
				for (int k = 0; k < len; k++)
					send_clean(pick_text(), 1'b0);
				send_clean(stt_pkg::CHAR_QUOTE, end_here);
			end else begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send_clean(8'($urandom_range(255)), $urandom_range(3) == 0);
			end
		end
		steady = 1'b0;
	endtask

	// Latch one kind of error, then check that it holds for every later item
	task automatic test_error_latch();
		int unsigned mode;
		mode = $urandom_range(3);
		if (in_str)
			send_item(stt_pkg::CHAR_QUOTE, 1'b0);
		send_item(CH_SPACE, 1'b0);
		case (mode)
			0: begin
				fault_path = "identifier too long";
				for (int i = 0; i < TOK_MAX; i++)
					send_item(pick_plain(), 1'b0);
			end
			1: begin
				fault_path = "string too long";
				send_item(stt_pkg::CHAR_QUOTE, 1'b0);
				for (int i = 0; i < TOK_MAX - 1; i++)
					send_item(pick_text(), 1'b0);
			end
			2: begin
				fault_path = "quote opened at source end after a token";
				send_item("a", 1'b0);
				send_item(stt_pkg::CHAR_QUOTE, 1'b1);
			end
			default: begin
				fault_path = "string still open at source end";
				send_item(stt_pkg::CHAR_QUOTE, 1'b0);
				send_item(pick_text(), 1'b0);
				send_item(pick_text(), 1'b1);
			end
		endcase
		for (int i = 0; i < 8; i++)
			send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// Randomly stall the result side
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	task automatic check_field(input string label, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", label, want, got);
			fail_count++;
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		stt_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (lexeme_q.size() == 0) begin
				$error("unexpected result: tdata %h, tlast %0d", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = lexeme_q.pop_front();
				check_field("out_byte",   want.data,       m_tdata[7:0]);
				check_field("has_byte",   want.has_byte,   m_tdata[8]);
				check_field("token_done", want.token_done, m_tdata[9]);
				check_field("error_code", want.error_code, m_tdata[11:10]);
				check_field("tdata pad",  0,               m_tdata[15:12]);
				check_field("last",       want.last,       m_tlast);
				lexemes_checked++;
				if (m_tdata[9])
					tokens_closed++;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_char_classes();
		test_length_limits();
		test_random_text();
		test_error_latch();
		drain_results();

		$display("Sent %0d bytes with %0d source ends; checked %0d results, %0d token ends.",
			byte_count, source_ends, lexemes_checked, tokens_closed);
		$display("Latched error path: %s.", fault_path);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/core/stt_pkg.sv
rtl/core/source_text_tokenizer_unit.sv
verif/source_text_tokenizer_unit_tb.sv
